### src/oat_pkg.sv
// Shared types and codes for the ordered array table.
package oat_pkg;

    typedef enum logic [3:0] {
        CMD_PUSH        = 4'd0,
        CMD_POP         = 4'd1,
        CMD_INSERT      = 4'd2,
        CMD_ERASE_ONE   = 4'd3,
        CMD_ERASE_RANGE = 4'd4,
        CMD_FIND        = 4'd5,
        CMD_READ        = 4'd6,
        CMD_WRITE       = 4'd7,
        CMD_CLEAR       = 4'd8
    } t_cmd;

    typedef enum logic [1:0] {
        STS_OK     = 2'd0,
        STS_BADPOS = 2'd1,
        STS_FULL   = 2'd2,
        STS_EMPTY  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ERASE,
        ST_FIND
    } t_state;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_SHIFT_UP,
        CELL_SHIFT_DOWN
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     cmp_en;
    } t_cell_ctl;

    typedef struct packed {
        logic [3:0]  cmd;
        logic [6:0]  position;
        logic [6:0]  end_position;
        logic [31:0] value;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] read_value;
        logic [6:0]  found_index;
        logic [6:0]  count;
        logic        is_empty;
        logic        is_full;
    } t_rsp;

endpackage

### src/oat_cell.sv
// One storage cell of the table: holds one entry, shifts with its neighbors and compares.
module oat_cell #(
    parameter int WORD_BITS = 32,
    parameter int PW        = 7,
    parameter int IDX       = 0
) (
    input  logic                  i_clk,
    input  oat_pkg::t_cell_ctl    i_ctl,
    input  logic [PW-1:0]         i_pos,
    input  logic [PW-1:0]         i_count,
    input  logic [WORD_BITS-1:0]  i_value,
    input  logic [WORD_BITS-1:0]  i_left,
    input  logic [WORD_BITS-1:0]  i_right,
    output logic [WORD_BITS-1:0]  o_data,
    output logic [WORD_BITS-1:0]  o_sel_data,
    output logic                  o_match
);
    import oat_pkg::*;

    localparam logic [PW-1:0] IDX_V = PW'(IDX);

    logic [WORD_BITS-1:0] r_data;
    logic [WORD_BITS-1:0] n_data;
    logic                 r_match;
    logic                 w_hit;
    logic                 w_above;

    assign w_hit   = (IDX_V == i_pos);
    assign w_above = (IDX_V > i_pos);

    always_comb begin
        n_data = r_data;
        case (i_ctl.op)
            CELL_LOAD: begin
                if (w_hit) begin
                    n_data = i_value;
                end
            end
            CELL_SHIFT_UP: begin
                if (w_hit) begin
                    n_data = i_value;
                end else if (w_above) begin
                    n_data = i_left;
                end
            end
            CELL_SHIFT_DOWN: begin
                if (w_hit || w_above) begin
                    n_data = i_right;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        if (i_ctl.cmp_en) begin
            r_match <= (IDX_V < i_count) && (r_data == i_value);
        end
    end

    assign o_data     = r_data;
    assign o_sel_data = r_data & {WORD_BITS{w_hit}};
    assign o_match    = r_match;

endmodule

### src/ordered_array_table_core.sv
// Top level of the ordered array table: command decode, count, result register and cell row.
//
// The table keeps up to CAPACITY words in a row of cells that shift together, with a
// live count. Push, pop, insert, erase of one entry, read, write and clear load their
// result on acceptance. For find, all cells compare in parallel, then a priority encoder
// picks the first match. Erase of a range moves the row down by one place per cycle until
// end_position - position entries are gone. The result register lets a new request be
// accepted in the cycle its predecessor's result is taken.
module ordered_array_table_core #(
    parameter int CAPACITY  = 64,
    parameter int WORD_BITS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  oat_pkg::t_req i_req,
    output logic          o_rsp_valid,
    input  logic          i_rsp_ready,
    output oat_pkg::t_rsp o_rsp
);
    import oat_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > 7) ? CW : 7;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    t_state               r_state;
    t_state               n_state;
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        n_count;
    logic [PW-1:0]        r_left;
    logic [PW-1:0]        n_left;
    logic [PW-1:0]        r_pos;
    logic [PW-1:0]        n_pos;
    logic                 r_out_valid;
    t_rsp                 r_out;
    t_rsp                 n_out;
    logic                 w_out_load;
    logic                 w_out_free;
    logic                 w_accept;
    logic [PW-1:0]        w_pos_x;
    logic [PW-1:0]        w_endp_x;
    logic [PW-1:0]        w_cnt_x;
    logic [WORD_BITS-1:0] w_val;
    logic                 w_full;
    logic                 w_empty;
    logic                 w_erase_ok;
    t_cell_ctl            w_ctl;
    logic [PW-1:0]        w_cell_pos;
    logic [WORD_BITS-1:0] w_data  [CAPACITY];
    logic [WORD_BITS-1:0] w_sel   [CAPACITY];
    logic [CAPACITY-1:0]  w_match;
    logic [WORD_BITS-1:0] w_sel_or;
    logic [CAPACITY-1:0]  w_lowest;
    logic [CW-1:0]        w_match_idx;
    logic                 w_any_match;

    assign w_out_free  = !r_out_valid || i_rsp_ready;
    assign o_req_ready = (r_state == ST_IDLE) && w_out_free;
    assign w_accept    = i_req_valid && o_req_ready;
    assign w_pos_x     = PW'(i_req.position);
    assign w_endp_x    = PW'(i_req.end_position);
    assign w_cnt_x     = PW'(r_count);
    assign w_val       = WORD_BITS'(i_req.value);
    assign w_full      = (r_count == CAP_C);
    assign w_empty     = (r_count == '0);
    assign w_erase_ok  = (w_endp_x >= w_pos_x) && (w_endp_x <= w_cnt_x);

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic [WORD_BITS-1:0] w_left;
        logic [WORD_BITS-1:0] w_right;
        if (k == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_data[k-1];
        end
        if (k == CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_data[k+1];
        end
        oat_cell #(
            .WORD_BITS(WORD_BITS),
            .PW       (PW),
            .IDX      (k)
        ) u_cell (
            .i_clk     (i_clk),
            .i_ctl     (w_ctl),
            .i_pos     (w_cell_pos),
            .i_count   (w_cnt_x),
            .i_value   (w_val),
            .i_left    (w_left),
            .i_right   (w_right),
            .o_data    (w_data[k]),
            .o_sel_data(w_sel[k]),
            .o_match   (w_match[k])
        );
    end

    always_comb begin
        w_sel_or = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            w_sel_or = w_sel_or | w_sel[k];
        end
    end

    assign w_lowest    = w_match & (~w_match + 1'b1);
    assign w_any_match = |w_match;

    always_comb begin
        w_match_idx = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            if (w_lowest[k]) begin
                w_match_idx = w_match_idx | CW'(k);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && (i_req.cmd == CMD_ERASE_RANGE) && w_erase_ok) begin
                    n_state = ST_ERASE;
                end else if (w_accept && (i_req.cmd == CMD_FIND)) begin
                    n_state = ST_FIND;
                end
            end
            ST_ERASE: begin
                if ((r_left == '0) && w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_FIND: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        w_ctl.op          = CELL_HOLD;
        w_ctl.cmp_en      = 1'b0;
        w_cell_pos        = w_pos_x;
        n_count           = r_count;
        n_left            = r_left;
        n_pos             = r_pos;
        w_out_load        = 1'b0;
        n_out.status      = STS_OK;
        n_out.read_value  = '0;
        n_out.found_index = '0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    w_out_load = 1'b1;
                    case (i_req.cmd)
                        CMD_PUSH: begin
                            if (w_full) begin
                                n_out.status = STS_FULL;
                            end else begin
                                w_ctl.op   = CELL_LOAD;
                                w_cell_pos = w_cnt_x;
                                n_count    = r_count + 1'b1;
                            end
                        end
                        CMD_POP: begin
                            if (w_empty) begin
                                n_out.status = STS_EMPTY;
                            end else begin
                                n_count = r_count - 1'b1;
                            end
                        end
                        CMD_INSERT: begin
                            if (w_pos_x > w_cnt_x) begin
                                n_out.status = STS_BADPOS;
                            end else if (w_full) begin
                                n_out.status = STS_FULL;
                            end else begin
                                w_ctl.op = CELL_SHIFT_UP;
                                n_count  = r_count + 1'b1;
                            end
                        end
                        CMD_ERASE_ONE: begin
                            if (w_pos_x >= w_cnt_x) begin
                                n_out.status = STS_BADPOS;
                            end else begin
                                w_ctl.op = CELL_SHIFT_DOWN;
                                n_count  = r_count - 1'b1;
                            end
                        end
                        CMD_ERASE_RANGE: begin
                            if (!w_erase_ok) begin
                                n_out.status = STS_BADPOS;
                            end else begin
                                w_out_load = 1'b0;
                                n_left     = w_endp_x - w_pos_x;
                                n_pos      = w_pos_x;
                            end
                        end
                        CMD_FIND: begin
                            w_out_load   = 1'b0;
                            w_ctl.cmp_en = 1'b1;
                        end
                        CMD_READ: begin
                            if (w_empty) begin
                                n_out.status = STS_EMPTY;
                            end else if (w_pos_x >= w_cnt_x) begin
                                n_out.status = STS_BADPOS;
                            end else begin
                                n_out.read_value = 32'(w_sel_or);
                            end
                        end
                        CMD_WRITE: begin
                            if (w_pos_x >= w_cnt_x) begin
                                n_out.status = STS_BADPOS;
                            end else begin
                                w_ctl.op = CELL_LOAD;
                            end
                        end
                        CMD_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                            n_count = r_count;
                        end
                    endcase
                end
            end
            ST_ERASE: begin
                if (r_left != '0) begin
                    w_ctl.op   = CELL_SHIFT_DOWN;
                    w_cell_pos = r_pos;
                    n_count    = r_count - 1'b1;
                    n_left     = r_left - 1'b1;
                end else if (w_out_free) begin
                    w_out_load = 1'b1;
                end
            end
            ST_FIND: begin
                if (w_out_free) begin
                    w_out_load        = 1'b1;
                    n_out.found_index = w_any_match ? 7'(w_match_idx) : 7'(r_count);
                end
            end
            default: begin
                w_out_load = 1'b0;
            end
        endcase
        n_out.count    = 7'(n_count);
        n_out.is_empty = (n_count == '0);
        n_out.is_full  = (n_count == CAP_C);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_left  <= n_left;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos <= n_pos;
        if (w_out_load) begin
            r_out <= n_out;
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_C)
        else $error("live count exceeds capacity");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_req.cmd == CMD_PUSH) && !w_full)
        |=> (r_count == CW'($past(r_count) + 1'b1)))
        else $error("accepted push did not grow the count");

    a_range_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_ERASE) && (r_left != '0))
        |=> (r_count == CW'($past(r_count) - 1'b1)))
        else $error("range erase step did not shrink the count");

    a_find_below_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIND) |-> (!w_any_match || (w_match_idx < r_count)))
        else $error("find matched an entry beyond the count");

endmodule

### tb/tb_ordered_array_table_core.sv
// Testbench for the ordered array table core: directed and random requests, shadow table.
`timescale 1ns / 1ps

module tb_ordered_array_table_core;
    import oat_pkg::*;

    localparam int TABLE_DEPTH  = 64;
    localparam int DRAIN_CYCLES = 100;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    t_req req       = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    t_rsp rsp;

    logic [31:0] shadow_words [TABLE_DEPTH];
    int unsigned shadow_count = 0;
    t_rsp        expected_rsps [$];
    t_rsp        head_rsp;
    int          idle_pct     = 37;
    int          stall_pct    = 37;
    int          error_count  = 0;
    int          cmd_seen [9] = '{default: 0};
    int          unused_seen  = 0;
    int          status_seen [4] = '{default: 0};

    ordered_array_table_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req_valid (req_valid),
        .o_req_ready (req_ready),
        .i_req       (req),
        .o_rsp_valid (rsp_valid),
        .i_rsp_ready (rsp_ready),
        .o_rsp       (rsp)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk) begin
        rsp_ready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic void drop_span(input int unsigned lo, input int unsigned hi);
        int unsigned i;
        int unsigned j;
        i = lo;
        j = hi;
        while (j < shadow_count) begin
            shadow_words[i] = shadow_words[j];
            i++;
            j++;
        end
        shadow_count -= (hi - lo);
    endfunction

    function automatic t_rsp apply_table_request(input t_req r);
        t_rsp        o;
        int unsigned p;
        int unsigned e;
        int unsigned k;
        o = '0;
        p = r.position;
        e = r.end_position;
        case (r.cmd)
            CMD_PUSH: begin
                if (shadow_count >= TABLE_DEPTH) begin
                    o.status = STS_FULL;
                end else begin
                    shadow_words[shadow_count] = r.value;
                    shadow_count++;
                end
            end
            CMD_POP: begin
                if (shadow_count == 0) begin
                    o.status = STS_EMPTY;
                end else begin
                    shadow_count--;
                end
            end
            CMD_INSERT: begin
                if (p > shadow_count) begin
                    o.status = STS_BADPOS;
                end else if (shadow_count >= TABLE_DEPTH) begin
                    o.status = STS_FULL;
                end else begin
                    for (k = shadow_count; k > p; k--) begin
                        shadow_words[k] = shadow_words[k - 1];
                    end
                    shadow_words[p] = r.value;
                    shadow_count++;
                end
            end
            CMD_ERASE_ONE: begin
                if (p >= shadow_count) begin
                    o.status = STS_BADPOS;
                end else begin
                    drop_span(p, p + 1);
                end
            end
            CMD_ERASE_RANGE: begin
                if (e < p || e > shadow_count) begin
                    o.status = STS_BADPOS;
                end else begin
                    drop_span(p, e);
                end
            end
            CMD_FIND: begin
                o.found_index = 7'(shadow_count);
                for (k = 0; k < shadow_count; k++) begin
                    if (shadow_words[k] == r.value) begin
                        o.found_index = 7'(k);
                        break;
                    end
                end
            end
            CMD_READ: begin
                if (shadow_count == 0) begin
                    o.status = STS_EMPTY;
                end else if (p >= shadow_count) begin
                    o.status = STS_BADPOS;
                end else begin
                    o.read_value = shadow_words[p];
                end
            end
            CMD_WRITE: begin
                if (p >= shadow_count) begin
                    o.status = STS_BADPOS;
                end else begin
                    shadow_words[p] = r.value;
                end
            end
            CMD_CLEAR: begin
                shadow_count = 0;
            end
            default: begin
            end
        endcase
        o.count    = 7'(shadow_count);
        o.is_empty = (shadow_count == 0);
        o.is_full  = (shadow_count == TABLE_DEPTH);
        return o;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
                $error("response with no request outstanding, count 0x%0h", rsp.count);
                error_count++;
            end else begin
                head_rsp = expected_rsps.pop_front();
                check_field("status", head_rsp.status, rsp.status);
                check_field("read_value", head_rsp.read_value, rsp.read_value);
                check_field("found_index", head_rsp.found_index, rsp.found_index);
                check_field("count", head_rsp.count, rsp.count);
                check_field("is_empty", head_rsp.is_empty, rsp.is_empty);
                check_field("is_full", head_rsp.is_full, rsp.is_full);
            end
        end
    end

    task automatic issue_request(input logic [3:0] cmd_code, input int pos, input int end_pos,
                                 input logic [31:0] word);
        t_req r;
        t_rsp predicted;
        r.cmd          = cmd_code;
        r.position     = 7'(pos);
        r.end_position = 7'(end_pos);
        r.value        = word;
        while ($urandom_range(99) < idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        predicted = apply_table_request(r);
        expected_rsps = {expected_rsps, predicted};
        if (r.cmd > CMD_CLEAR) begin
            unused_seen++;
        end else begin
            cmd_seen[r.cmd]++;
        end
        status_seen[predicted.status]++;
    endtask

    task automatic wait_for_results();
        req_valid <= 1'b0;
        @(posedge clk);
        while (expected_rsps.size() != 0) @(posedge clk);
    endtask

    task automatic test_empty_table();
        issue_request(CMD_POP, 0, 0, 32'h0);
        issue_request(CMD_READ, 0, 0, 32'h0);
        issue_request(CMD_ERASE_ONE, 0, 0, 32'h0);
        issue_request(CMD_WRITE, 0, 0, 32'h1234);
        issue_request(CMD_ERASE_RANGE, 0, 0, 32'h0);
        issue_request(CMD_ERASE_RANGE, 0, 1, 32'h0);
        issue_request(CMD_FIND, 0, 0, 32'h0);
        issue_request(CMD_INSERT, 1, 0, 32'h55);
        issue_request(4'd9, 0, 0, 32'h0);
    endtask

    task automatic test_basic_edits();
        issue_request(CMD_PUSH, 0, 0, 32'hFFFF_FFFF);
        issue_request(CMD_PUSH, 0, 0, 32'h0);
        issue_request(CMD_INSERT, 0, 0, 32'h8000_0001);
        issue_request(CMD_INSERT, 3, 0, 32'h1234_5678);
        issue_request(CMD_INSERT, 127, 0, 32'h1);
        issue_request(CMD_READ, 0, 0, 32'h0);
        issue_request(CMD_READ, 127, 0, 32'h0);
        issue_request(CMD_WRITE, 1, 0, 32'hA5A5_A5A5);
        issue_request(CMD_FIND, 0, 0, 32'hA5A5_A5A5);
        issue_request(CMD_FIND, 0, 0, 32'hDEAD_BEEF);
        issue_request(CMD_ERASE_ONE, 0, 0, 32'h0);
        issue_request(CMD_ERASE_RANGE, 2, 1, 32'h0);
        issue_request(CMD_ERASE_RANGE, 0, 127, 32'h0);
        issue_request(CMD_ERASE_RANGE, 1, 2, 32'h0);
        issue_request(CMD_ERASE_RANGE, 1, 1, 32'h0);
        issue_request(4'd15, 127, 127, 32'hFFFF_FFFF);
        issue_request(CMD_CLEAR, 0, 0, 32'h0);
    endtask

    task automatic test_full_table();
        idle_pct  = 0;
        stall_pct = 0;
        while (shadow_count < TABLE_DEPTH) begin
            issue_request(CMD_PUSH, 0, 0, $urandom());
        end
        issue_request(CMD_PUSH, 0, 0, 32'h7);
        issue_request(CMD_INSERT, 64, 0, 32'h7);
        issue_request(CMD_INSERT, 65, 0, 32'h7);
        issue_request(CMD_INSERT, 0, 0, 32'h7);
        issue_request(CMD_FIND, 0, 0, shadow_words[TABLE_DEPTH - 1]);
        issue_request(CMD_WRITE, 63, 0, 32'hFFFF_FFFF);
        issue_request(CMD_READ, 63, 0, 32'h0);
        issue_request(CMD_ERASE_RANGE, 0, 64, 32'h0);
        while (shadow_count < TABLE_DEPTH) begin
            issue_request(CMD_INSERT, $urandom_range(shadow_count), 0, $urandom());
        end
        issue_request(CMD_READ, 64, 0, 32'h0);
        while (shadow_count > 0) begin
            issue_request(CMD_ERASE_ONE, $urandom_range(shadow_count - 1), 0, 32'h0);
        end
        issue_request(CMD_POP, 0, 0, 32'h0);
        idle_pct  = 37;
        stall_pct = 37;
    endtask

    task automatic test_random_commands(input int n);
        logic [3:0]  c;
        int          p;
        int          e;
        int          cnt;
        int          grow;
        logic [31:0] v;
        for (int i = 0; i < n; i++) begin
            if (i == n / 2) begin
                wait_for_results();
            end
            cnt = shadow_count;
            v   = ($urandom_range(4) == 0) ? 32'($urandom_range(7)) : $urandom();
            p   = $urandom_range(127);
            e   = $urandom_range(127);
            if ($urandom_range(99) < 6) begin
                c = 4'($urandom_range(15));
            end else begin
                grow = (cnt < 12) ? 65 : (cnt > 58) ? 20 : 42;
                if ($urandom_range(99) < grow) begin
                    c = $urandom_range(1) ? CMD_PUSH : CMD_INSERT;
                end else begin
                    case ($urandom_range(15))
                        0, 1:     c = CMD_POP;
                        2, 3:     c = CMD_ERASE_ONE;
                        4, 5, 6:  c = CMD_ERASE_RANGE;
                        7, 8, 9:  c = CMD_FIND;
                        10, 11, 12: c = CMD_READ;
                        13, 14:   c = CMD_WRITE;
                        default:  c = ($urandom_range(4) == 0) ? CMD_CLEAR : CMD_READ;
                    endcase
                end
                if ($urandom_range(99) < 88) begin
                    case (c)
                        CMD_INSERT: p = $urandom_range(cnt);
                        CMD_ERASE_RANGE: begin
                            p = $urandom_range(cnt);
                            if ($urandom_range(99) < 8) begin
                                e = p + $urandom_range(cnt - p);
                            end else begin
                                e = p + $urandom_range((cnt - p < 3) ? cnt - p : 3);
                            end
                        end
                        default: begin
                            if (cnt > 0) p = $urandom_range(cnt - 1);
                        end
                    endcase
                end
                if (c == CMD_FIND && cnt > 0 && $urandom_range(99) < 60) begin
                    v = shadow_words[$urandom_range(cnt - 1)];
                end
            end
            issue_request(c, p, e, v);
        end
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_table();
        test_basic_edits();
        test_full_table();
        test_random_commands(822);
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Requests: push %0d, pop %0d, insert %0d, erase one %0d, erase range %0d,",
                 cmd_seen[CMD_PUSH], cmd_seen[CMD_POP], cmd_seen[CMD_INSERT],
                 cmd_seen[CMD_ERASE_ONE], cmd_seen[CMD_ERASE_RANGE]);
        $write("  find %0d, read %0d, write %0d, clear %0d, unused %0d; ",
               cmd_seen[CMD_FIND], cmd_seen[CMD_READ], cmd_seen[CMD_WRITE],
               cmd_seen[CMD_CLEAR], unused_seen);
        $display("ok %0d, bad position %0d, full %0d, empty %0d.",
                 status_seen[STS_OK], status_seen[STS_BADPOS],
                 status_seen[STS_FULL], status_seen[STS_EMPTY]);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

### sim.f
src/oat_pkg.sv
src/oat_cell.sv
src/ordered_array_table_core.sv
tb/tb_ordered_array_table_core.sv
